[src/ssm_pkg.sv]
// ============================================================================
// ssm_pkg: shared types and constants of the substring search matcher
// Register indexes of the configuration port, widths of the pattern registers
// and the control word that steps the chain of window cells.
// ============================================================================
package ssm_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int PATTERN_BITS = 64;
    localparam int LENGTH_BITS  = 4;
    localparam int OUT_INDEX_BITS = 16;

    // Configuration register indexes.
    localparam logic REG_PATTERN_BYTES  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic shift;    // take a new byte from the neighbor
        logic clear;    // end of text: empty the window
    } cell_ctl_t;

endpackage

[src/ssm_cell.sv]
// ============================================================================
// ssm_cell: one stage of the text window
// Compares the byte it sees against the pattern byte that lines up with its
// age, and holds that byte for the next cell of the chain.
// ============================================================================
module ssm_cell #(
    parameter int CELL_AGE = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ssm_pkg::cell_ctl_t                  ctl,
    input  logic [ssm_pkg::BYTE_BITS-1:0]       byte_in,
    input  logic [ssm_pkg::PATTERN_BITS-1:0]    pattern_bytes,
    input  logic [ssm_pkg::LENGTH_BITS-1:0]     pattern_length,
    output logic [ssm_pkg::BYTE_BITS-1:0]       byte_out,
    output logic                                ok
);

    localparam logic [ssm_pkg::LENGTH_BITS-1:0] AGE = ssm_pkg::LENGTH_BITS'(CELL_AGE);

    logic [ssm_pkg::BYTE_BITS-1:0]   win_reg;
    logic [ssm_pkg::BYTE_BITS-1:0]   win_next;
    logic [ssm_pkg::LENGTH_BITS-1:0] pat_pos;
    logic [ssm_pkg::BYTE_BITS-1:0]   pat_byte;
    logic                            active;

    // The byte of age a lines up with pattern byte length-1-a.
    assign active   = AGE < pattern_length;
    assign pat_pos  = pattern_length - AGE - ssm_pkg::LENGTH_BITS'(1);
    assign pat_byte = pattern_bytes[pat_pos[2:0]*ssm_pkg::BYTE_BITS +: ssm_pkg::BYTE_BITS];
    assign ok       = !active || (byte_in == pat_byte);

    always_comb begin
        win_next = win_reg;
        if (ctl.clear) begin
            win_next = '0;
        end else if (ctl.shift) begin
            win_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    assign byte_out = win_reg;

endmodule

[src/substring_search_matcher_core.sv]
// ============================================================================
// substring_search_matcher_core: streaming search for a short byte pattern
// Accepts one text byte per word, compares the newest bytes against the
// pattern in a chain of window cells and reports the first occurrence.
// ============================================================================
// The result is registered and appears on the output register in the cycle after
// the last byte of a text is accepted.
// Throughput: one byte per cycle; the window compare finishes in the cycle the
// byte arrives. A result that the receiver has not yet taken stalls the input.
// Reset: synchronous, active low; clears the pattern registers, the window,
// the position counter and the match state.
module substring_search_matcher_core #(
    parameter int MAX_PATTERN = 8,
    parameter int INDEX_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [ssm_pkg::PATTERN_BITS-1:0]      cfg_data,
    // Text input.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [7:0] text_byte
    input  logic                                  s_tlast,   // is_last
    // Result output.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [15:0]                           m_tdata,   // [15:0] match_index
    output logic                                  m_tuser    // [0] found
);

    localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};
    localparam int WIDE_BITS = (INDEX_BITS > ssm_pkg::OUT_INDEX_BITS) ?
                               INDEX_BITS : ssm_pkg::OUT_INDEX_BITS;
    localparam logic [ssm_pkg::LENGTH_BITS-1:0] MAX_LEN =
        ssm_pkg::LENGTH_BITS'(MAX_PATTERN);

    logic [ssm_pkg::PATTERN_BITS-1:0] pat_bytes_reg;
    logic [ssm_pkg::PATTERN_BITS-1:0] pat_bytes_next;
    logic [ssm_pkg::LENGTH_BITS-1:0]  pat_len_reg;
    logic [ssm_pkg::LENGTH_BITS-1:0]  pat_len_next;

    logic [INDEX_BITS-1:0] pos_reg;
    logic [INDEX_BITS-1:0] pos_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic [INDEX_BITS-1:0] first_reg;
    logic [INDEX_BITS-1:0] first_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_found_reg;
    logic        out_found_next;
    logic [15:0] out_index_reg;
    logic [15:0] out_index_next;

    logic                  acc;
    ssm_pkg::cell_ctl_t    ctl;
    logic [ssm_pkg::BYTE_BITS-1:0] win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    logic [INDEX_BITS-1:0] len_m1;
    logic                  len_zero;
    logic                  new_hit;
    logic                  seen_now;
    logic [INDEX_BITS-1:0] hit_idx;
    logic [INDEX_BITS-1:0] idx_now;
    logic [WIDE_BITS-1:0]  idx_wide;

    assign cfg_ready = 1'b1;

    always_comb begin
        pat_bytes_next = pat_bytes_reg;
        pat_len_next   = pat_len_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ssm_pkg::REG_PATTERN_BYTES: begin
                    pat_bytes_next = cfg_data;
                end
                ssm_pkg::REG_PATTERN_LENGTH: begin
                    pat_len_next = cfg_data[ssm_pkg::LENGTH_BITS-1:0];
                end
                default: begin
                    pat_bytes_next = pat_bytes_reg;
                end
            endcase
        end
    end

    // The output register frees up when its word is taken in the same cycle.
    assign s_tready  = !out_valid_reg || m_tready;
    assign acc       = s_tvalid && s_tready;
    assign ctl.shift = acc && !s_tlast;
    assign ctl.clear = acc && s_tlast;

    assign win[0] = s_tdata;

    for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
        if (a < MAX_PATTERN - 1) begin : g_mid
            ssm_cell #(.CELL_AGE(a)) u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .ctl            (ctl),
                .byte_in        (win[a]),
                .pattern_bytes  (pat_bytes_reg),
                .pattern_length (pat_len_reg),
                .byte_out       (win[a+1]),
                .ok             (cell_ok[a])
            );
        end else begin : g_end
            ssm_cell #(.CELL_AGE(a)) u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .ctl            (ctl),
                .byte_in        (win[a]),
                .pattern_bytes  (pat_bytes_reg),
                .pattern_length (pat_len_reg),
                .byte_out       (),
                .ok             (cell_ok[a])
            );
        end
    end

    assign len_m1   = INDEX_BITS'(pat_len_reg) - INDEX_BITS'(1);
    assign len_zero = (pat_len_reg == '0);
    // A match needs the whole pattern inside the text, and none is taken once
    // the position counter has saturated.
    assign new_hit  = !seen_reg && (pos_reg != POS_MAX) &&
                      (len_zero || ((pat_len_reg <= MAX_LEN) && (pos_reg >= len_m1) &&
                                    (&cell_ok)));
    assign hit_idx  = len_zero ? '0 : (pos_reg - len_m1);
    assign seen_now = seen_reg || new_hit;
    assign idx_now  = seen_reg ? first_reg : (new_hit ? hit_idx : '0);
    assign idx_wide = WIDE_BITS'(idx_now);

    always_comb begin
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        if (acc) begin
            if (s_tlast) begin
                out_valid_next = 1'b1;
                out_found_next = seen_now;
                out_index_next = idx_wide[15:0];
                pos_next       = '0;
                seen_next      = 1'b0;
                first_next     = '0;
            end else begin
                seen_next  = seen_now;
                first_next = idx_now;
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + INDEX_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pat_bytes_reg <= pat_bytes_next;
            pat_len_reg   <= pat_len_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_index_reg;

`ifndef SYNTHESIS
    // A result only appears after the last byte of a text was taken.
    a_result_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result raised without a last byte");

    // The end of a text leaves the per-text state empty.
    a_text_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (pos_reg == '0 && !seen_reg))
        else $error("per-text state not cleared after last byte");

    // A text without a match reports index zero.
    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0))
        else $error("nonzero index reported without a match");
`endif

endmodule

[test/testbench.sv]
// ============================================================================
// testbench: self-checking bench for substring_search_matcher_core
// Streams texts into the matcher under several pattern settings, predicts the
// found flag and first match index of every text, and compares each result
// word against the prediction. Covers the empty and over-long patterns,
// matches at the text start and repeated matches.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH = 7;
    localparam int MAX_PAT      = 8;
    localparam int POS_LIMIT    = 65535;
    localparam int SETTLE_TICKS = 4;

    typedef struct packed {
        logic        found;
        logic [15:0] index;
    } verdict_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = ssm_pkg::REG_PATTERN_BYTES;
    logic [63:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] text_byte
    logic        s_tlast   = 1'b0; // is_last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [15:0] match_index
    logic        m_tuser;          // [0] found

    // Predicted matcher state.
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = '0;
    logic [7:0]  history [0:WINDOW_DEPTH-1];
    int          text_pos;
    logic        hit_seen;
    int          hit_start;

    verdict_t    pending_verdicts [$];
    verdict_t    head_verdict;
    int          error_count = 0;
    int          send_idle = 0;
    int          recv_idle = 0;

    substring_search_matcher_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic clear_text;
        for (int k = 0; k < WINDOW_DEPTH; k++) history[k] = '0;
        text_pos  = 0;
        hit_seen  = 1'b0;
        hit_start = 0;
    endtask

    // Advances the predicted state by one text byte and queues the verdict on
    // the last byte of a text.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        int         len;
        int         age;
        logic       same;
        logic [7:0] tb;
        len = pat_len;
        if (!hit_seen && text_pos < POS_LIMIT) begin
            if (len == 0) begin
                hit_seen  = 1'b1;
                hit_start = 0;
            end else if (len <= MAX_PAT && text_pos >= len - 1) begin
                same = 1'b1;
                for (int k = 0; k < len; k++) begin
                    age = len - 1 - k;
                    tb  = (age == 0) ? b : history[age - 1];
                    if (tb != pat_bytes[8*k +: 8]) same = 1'b0;
                end
                if (same) begin
                    hit_seen  = 1'b1;
                    hit_start = text_pos - (len - 1);
                end
            end
        end
        if (last) begin
            pending_verdicts.push_back('{found: hit_seen,
                                         index: hit_seen ? hit_start[15:0] : 16'd0});
            clear_text();
        end else begin
            for (int k = WINDOW_DEPTH - 1; k > 0; k--) history[k] = history[k - 1];
            history[0] = b;
            if (text_pos < POS_LIMIT) text_pos++;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result word with none expected (found %0b index %0d)",
                                          m_tuser, m_tdata));
            end else begin
                head_verdict = pending_verdicts.pop_front();
                if (m_tuser !== head_verdict.found)
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              m_tuser, head_verdict.found));
                if (m_tdata !== head_verdict.index)
                    report_mismatch($sformatf("match_index %0d, expected %0d",
                                              m_tdata, head_verdict.index));
            end
        end
    end

    // The prediction is made when the word is presented; valid stays high
    // until it is taken, so the word is certain to be accepted.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        predict_byte(b, last);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the input off until every pending result has come out, then lets
    // the last byte without a result settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == ssm_pkg::REG_PATTERN_BYTES) pat_bytes = value;
        else pat_len = value[3:0];
    endtask

    // Only the low four bits of the length word count, so the rest is noise.
    task automatic set_pattern(input logic [63:0] bytes, input logic [3:0] len);
        logic [63:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[3:0] = len;
        drain();
        write_reg(ssm_pkg::REG_PATTERN_BYTES, bytes);
        write_reg(ssm_pkg::REG_PATTERN_LENGTH, len_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed;
        // Empty pattern matches at the start of any text.
        set_pattern(64'h0, 4'd0);
        send_byte(8'h00, 1'b1);
        // Full-width pattern at the extreme byte value, matching at index 0.
        set_pattern('1, 4'd8);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // A length above the window never matches.
        set_pattern(64'h0, 4'd15);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // The zeroed window must not complete a match before enough bytes came.
        set_pattern(64'h0, 4'd2);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // Only the first of two occurrences is reported.
        set_pattern(64'h4241, 4'd2);
        send_byte(8'h78, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
    endtask

    task automatic pick_pattern;
        logic [63:0] bytes;
        logic [7:0]  a;
        logic [7:0]  b;
        int          pick;
        logic [3:0]  len;
        bytes = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 30) begin
            // Two-letter pattern so that overlapping partial matches occur.
            a = 8'($urandom);
            b = 8'($urandom);
            for (int k = 0; k < 8; k++) bytes[8*k +: 8] = $urandom_range(0, 1) ? a : b;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) len = 4'd0;
        else if (pick < 18) len = 4'($urandom_range(9, 15));
        else len = 4'($urandom_range(1, 8));
        set_pattern(bytes, len);
    endtask

    // Texts are mostly built from pattern bytes, often with a whole pattern
    // planted, so partial and full matches are frequent.
    task automatic send_text(output int count);
        int         plen;
        int         tlen;
        int         spot;
        logic       plant;
        logic [7:0] b;
        plen  = (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
        tlen  = $urandom_range(1, plen + 12);
        plant = ($urandom_range(0, 99) < 55) && (tlen >= plen);
        spot  = plant ? $urandom_range(0, tlen - plen) : 0;
        for (int i = 0; i < tlen; i++) begin
            if (plant && i >= spot && i < spot + plen) b = pat_bytes[8*(i - spot) +: 8];
            else if ($urandom_range(0, 99) < 60) b = pat_bytes[8*$urandom_range(0, 7) +: 8];
            else b = 8'($urandom);
            send_byte(b, i == tlen - 1);
        end
        count = tlen;
    endtask

    task automatic test_random(input int item_goal);
        int sent;
        int text_items;
        int texts_left;
        sent = 0;
        texts_left = 0;
        while (sent < item_goal) begin
            if (texts_left == 0) begin
                pick_pattern();
                texts_left = $urandom_range(3, 12);
            end
            if ($urandom_range(0, 99) < 10) drain();
            send_text(text_items);
            sent += text_items;
            texts_left--;
        end
    endtask

    initial begin
        clear_text();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 31;
        recv_idle = 77;
        test_directed();
        test_random(250);

        send_idle = 77;
        recv_idle = 31;
        test_random(250);

        send_idle = 0;
        recv_idle = 0;
        test_random(200);

        drain();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/ssm_pkg.sv
src/ssm_cell.sv
src/substring_search_matcher_core.sv
test/testbench.sv
